/* sv/fpba_pkg.sv */
// fpba_pkg: sizes, codes and bus types of the fit-policy block allocator
// used by the interfaces, the search cell, the top level and the checker

package fpba_pkg;

    // table geometry
    localparam int unsigned NUM_BLOCKS = 32;
    localparam int unsigned SIZE_WIDTH = 16;
    localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);

    // field widths fixed by the channels
    localparam int unsigned CMD_W      = 1;
    localparam int unsigned BIDX_W     = 5;
    localparam int unsigned FSIZE_W    = 16;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned BCNT_W     = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;

    // compare widths wide enough for both operands
    localparam int unsigned CMP_W  = (SIZE_WIDTH > FSIZE_W) ? SIZE_WIDTH : FSIZE_W;
    localparam int unsigned CNT_W  = (IDX_W > BCNT_W) ? IDX_W : BCNT_W;
    localparam int unsigned LIDX_W = (IDX_W > BIDX_W) ? IDX_W : BIDX_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    // placement policies, the unused code acts as first fit
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [SIZE_WIDTH-1:0] t_size;
    typedef logic [CMP_W-1:0]      t_cmp;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [LIDX_W-1:0]     t_lidx;

    // search token handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  found;
        t_idx  pick;
        t_size psize;
    } t_token;

    // load broadcast to all cells
    typedef struct packed {
        logic  valid;
        t_lidx index;
        t_size size;
    } t_load;

    // charge of the chosen block after a search
    typedef struct packed {
        logic  valid;
        t_idx  pick;
        t_size size;
    } t_charge;

endpackage

/* sv/fpba_if.sv */
// fpba_if: request, response and register write channels of the allocator
// depends on fpba_pkg for field widths

interface fpba_req_if;
    logic                           valid;
    logic                           ready;
    logic [fpba_pkg::CMD_W-1:0]     command;
    logic [fpba_pkg::BIDX_W-1:0]    block_index;
    logic [fpba_pkg::FSIZE_W-1:0]   block_size;
    logic [fpba_pkg::FSIZE_W-1:0]   request_size;

    modport source (output valid, command, block_index, block_size, request_size,
                    input ready);
    modport sink   (input valid, command, block_index, block_size, request_size,
                    output ready);
endinterface

interface fpba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           granted;
    logic [fpba_pkg::BIDX_W-1:0]    chosen_block;
    logic [fpba_pkg::FSIZE_W-1:0]   remaining_size;

    modport source (output valid, granted, chosen_block, remaining_size, input ready);
    modport sink   (input valid, granted, chosen_block, remaining_size, output ready);
endinterface

interface fpba_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fpba_pkg::CFG_IDX_W-1:0]   index;
    logic [fpba_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/fpba_cell.sv */
// fpba_cell: one table entry of the allocator and one step of the search chain
// depends on fpba_pkg for widths, policy codes and bus types

module fpba_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fpba_pkg::t_idx                i_index,
    input  logic [fpba_pkg::MODE_W-1:0]   i_fit_mode,
    input  logic [fpba_pkg::BCNT_W-1:0]   i_block_count,
    input  logic [fpba_pkg::FSIZE_W-1:0]  i_request,
    input  fpba_pkg::t_load               i_load,
    input  fpba_pkg::t_charge             i_charge,
    input  fpba_pkg::t_token              i_token,
    output fpba_pkg::t_token              o_token
);

    fpba_pkg::t_size  r_size, n_size;
    fpba_pkg::t_token r_token, n_token;
    logic             w_active;
    logic             w_fits;
    logic             w_better;

    // entry lies inside the searched range and holds the request
    assign w_active = fpba_pkg::t_cnt'(i_index) < fpba_pkg::t_cnt'(i_block_count);
    assign w_fits   = fpba_pkg::t_cmp'(r_size) >= fpba_pkg::t_cmp'(i_request);

    // strict compare keeps ties on the lower index
    always_comb begin
        case (i_fit_mode)
            fpba_pkg::MODE_BEST:  w_better = r_size < i_token.psize;
            fpba_pkg::MODE_WORST: w_better = r_size > i_token.psize;
            default:              w_better = 1'b0;
        endcase
    end

    // update the passing token
    always_comb begin
        n_token = i_token;
        if (i_token.valid && w_active && w_fits && (!i_token.found || w_better)) begin
            n_token.found = 1'b1;
            n_token.pick  = i_index;
            n_token.psize = r_size;
        end
    end

    // entry write by load or by charge
    always_comb begin
        n_size = r_size;
        if (i_load.valid && (i_load.index == fpba_pkg::t_lidx'(i_index))) begin
            n_size = i_load.size;
        end else if (i_charge.valid && (i_charge.pick == i_index)) begin
            n_size = i_charge.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_token <= '0;
        end else begin
            r_size  <= n_size;
            r_token <= n_token;
        end
    end

    assign o_token = r_token;

endmodule

/* sv/fit_policy_block_allocator.sv */
// fit_policy_block_allocator: table of free block sizes with first, best and
// worst fit placement; depends on fpba_pkg, fpba_if and fpba_cell
//
// Channels: i_req takes words of command, block_index, block_size and
// request_size; o_rsp gives one word of granted, chosen_block and
// remaining_size for each allocate; i_cfg writes fit_mode (index 0) and
// block_count (index 1); the user must write it only while the block is idle,
// which the block itself does not enforce. A load gives no response word.
// An allocate launches a token down a row of NUM_BLOCKS cells, one cell a
// cycle, each cell holding one entry and keeping the best pick so far. The
// last cell's token charges the chosen entry and forms the response.
// One allocate is in flight at a time; i_req.ready is low during the scan.
// The response register frees the scan from the receiver: if o_rsp is
// stalled when a search ends, the result waits in a hold register and
// i_req stays not ready until it moves into the response register.
// Synchronous reset clears every table entry, both config registers and o_rsp.valid.

module fit_policy_block_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fpba_req_if.sink          i_req,
    fpba_rsp_if.source        o_rsp,
    fpba_cfg_if.sink          i_cfg
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                          r_state, n_state;
    logic [fpba_pkg::MODE_W-1:0]         r_fit_mode;
    logic [fpba_pkg::BCNT_W-1:0]         r_block_count;
    logic [fpba_pkg::FSIZE_W-1:0]        r_request;
    logic                                r_launch;
    logic                                r_hold_granted;
    logic [fpba_pkg::BIDX_W-1:0]         r_hold_block;
    logic [fpba_pkg::FSIZE_W-1:0]        r_hold_remain;
    logic                                r_out_valid, n_out_valid;
    logic                                r_out_granted;
    logic [fpba_pkg::BIDX_W-1:0]         r_out_block;
    logic [fpba_pkg::FSIZE_W-1:0]        r_out_remain;

    logic                                w_accept;
    logic                                w_slot_free;
    logic                                w_scan_end;
    logic                                w_load_out;
    fpba_pkg::t_load                     w_load;
    fpba_pkg::t_charge                   w_charge;
    fpba_pkg::t_token                    w_token [fpba_pkg::NUM_BLOCKS+1];
    fpba_pkg::t_token                    w_last;
    fpba_pkg::t_size                     w_new_size;
    logic                                w_res_granted;
    logic [fpba_pkg::BIDX_W-1:0]         w_res_block;
    logic [fpba_pkg::FSIZE_W-1:0]        w_res_remain;

    // handshakes
    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    // load broadcast, entries outside the table match no cell
    assign w_load.valid = w_accept && (i_req.command == fpba_pkg::CMD_LOAD);
    assign w_load.index = fpba_pkg::t_lidx'(i_req.block_index);
    assign w_load.size  = fpba_pkg::t_size'(i_req.block_size);

    // token entering the first cell
    assign w_token[0].valid = r_launch;
    assign w_token[0].found = 1'b0;
    assign w_token[0].pick  = '0;
    assign w_token[0].psize = '0;

    // row of cells
    for (genvar k = 0; k < fpba_pkg::NUM_BLOCKS; k++) begin : g_cell
        fpba_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_index       (fpba_pkg::t_idx'(k)),
            .i_fit_mode    (r_fit_mode),
            .i_block_count (r_block_count),
            .i_request     (r_request),
            .i_load        (w_load),
            .i_charge      (w_charge),
            .i_token       (w_token[k]),
            .o_token       (w_token[k+1])
        );
    end

    // result of the search leaving the last cell
    assign w_last        = w_token[fpba_pkg::NUM_BLOCKS];
    assign w_scan_end    = (r_state == ST_SCAN) && w_last.valid;
    assign w_new_size    = w_last.psize - fpba_pkg::t_size'(r_request);
    assign w_res_granted = w_last.found;
    assign w_res_block   = w_last.found ? fpba_pkg::BIDX_W'(w_last.pick) : '0;
    assign w_res_remain  = w_last.found ? fpba_pkg::FSIZE_W'(w_new_size) : '0;

    assign w_charge.valid = w_scan_end && w_last.found;
    assign w_charge.pick  = w_last.pick;
    assign w_charge.size  = w_new_size;

    assign w_load_out = w_slot_free && (w_scan_end || (r_state == ST_HOLD));

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_req.command == fpba_pkg::CMD_ALLOC)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_last.valid) begin
                    n_state = w_slot_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // response valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_launch      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_fit_mode    <= fpba_pkg::MODE_FIRST;
            r_block_count <= '0;
        end else begin
            r_state     <= n_state;
            r_launch    <= w_accept && (i_req.command == fpba_pkg::CMD_ALLOC);
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    fpba_pkg::CFG_FIT_MODE:    r_fit_mode    <= i_cfg.data[fpba_pkg::MODE_W-1:0];
                    fpba_pkg::CFG_BLOCK_COUNT: r_block_count <= i_cfg.data[fpba_pkg::BCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req.command == fpba_pkg::CMD_ALLOC)) begin
            r_request <= i_req.request_size;
        end
        if (w_scan_end) begin
            r_hold_granted <= w_res_granted;
            r_hold_block   <= w_res_block;
            r_hold_remain  <= w_res_remain;
        end
        if (w_load_out) begin
            r_out_granted <= (r_state == ST_HOLD) ? r_hold_granted : w_res_granted;
            r_out_block   <= (r_state == ST_HOLD) ? r_hold_block   : w_res_block;
            r_out_remain  <= (r_state == ST_HOLD) ? r_hold_remain  : w_res_remain;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.granted        = r_out_granted;
    assign o_rsp.chosen_block   = r_out_block;
    assign o_rsp.remaining_size = r_out_remain;

endmodule

/* sv/fpba_checker.sv */
// fpba_checker: port-level assertions on the allocator, bound to the top level
// depends on fpba_pkg and on the ports of fit_policy_block_allocator

module fpba_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic [fpba_pkg::CMD_W-1:0]     i_in_command,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_granted,
    input logic [fpba_pkg::BIDX_W-1:0]    i_chosen_block,
    input logic [fpba_pkg::FSIZE_W-1:0]   i_remaining_size
);

    // reset empties the response register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // a refused request reports zero index and zero size
    a_denied_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_granted) |-> (i_chosen_block == '0 && i_remaining_size == '0))
        else $error("denied response carries nonzero fields");

    // an allocate word starts a scan, so no word is taken in the next cycle
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == fpba_pkg::CMD_ALLOC) |=> !i_in_ready)
        else $error("request taken during a scan");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_granted) && $stable(i_chosen_block)
         && $stable(i_remaining_size)))
        else $error("stalled response changed");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_in_command     (i_req.command),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_granted        (o_rsp.granted),
    .i_chosen_block   (o_rsp.chosen_block),
    .i_remaining_size (o_rsp.remaining_size)
);
